/* rtl/core/ssj_pkg.sv */
// types and constants shared by the stream join cells and the top level
package ssj_pkg;

   localparam int FIELD_BITS = 64;

   localparam logic SIDE_LEFT  = 1'b0;
   localparam logic SIDE_RIGHT = 1'b1;

   typedef struct packed {
      logic                  opcode;
      logic                  key_is_null;
      logic [FIELD_BITS-1:0] join_key;
      logic [FIELD_BITS-1:0] row_payload;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] left_row;
      logic [FIELD_BITS-1:0] right_row;
      logic [FIELD_BITS-1:0] matched_key;
      logic                  last_match;
      logic                  store_overflow;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic probe_side;
      logic shift_left;
      logic shift_right;
      logic take;
   } cell_ctrl_type;

endpackage

/* rtl/core/ssj_cell.sv */
// one slot of each side's row store, with its own key compare and match flag
module ssj_cell #(
   parameter int ROWS_PER_SIDE = 64,
   parameter int KEY_BITS      = 64,
   parameter int PAYLOAD_BITS  = 64,
   parameter int INDEX         = 0,
   parameter int FW            = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ssj_pkg::cell_ctrl_type      ctrl,
   input  logic [KEY_BITS-1:0]         probe_key,
   input  logic [FW-1:0]               left_fill,
   input  logic [FW-1:0]               right_fill,
   input  logic [KEY_BITS-1:0]         up_left_key,
   input  logic [PAYLOAD_BITS-1:0]     up_left_pay,
   input  logic [KEY_BITS-1:0]         up_right_key,
   input  logic [PAYLOAD_BITS-1:0]     up_right_pay,
   input  logic                        grant,
   output logic [KEY_BITS-1:0]         left_key,
   output logic [PAYLOAD_BITS-1:0]     left_pay,
   output logic [KEY_BITS-1:0]         right_key,
   output logic [PAYLOAD_BITS-1:0]     right_pay,
   output logic                        pending,
   output logic [PAYLOAD_BITS-1:0]     sel_pay
);
   import ssj_pkg::*;

   localparam logic [FW-1:0] THRESH = FW'(ROWS_PER_SIDE - INDEX);

   logic [KEY_BITS-1:0]     left_key_ff, right_key_ff;
   logic [PAYLOAD_BITS-1:0] left_pay_ff, right_pay_ff;
   logic                    match_ff, match_in;
   logic                    left_valid, right_valid, opp_valid;
   logic [KEY_BITS-1:0]     opp_key;

   // newest word enters at the top cell, older ones move down
   always_ff @(posedge clock) begin
      if (ctrl.shift_left) begin
         left_key_ff <= up_left_key;
         left_pay_ff <= up_left_pay;
      end
      if (ctrl.shift_right) begin
         right_key_ff <= up_right_key;
         right_pay_ff <= up_right_pay;
      end
   end

   always_comb begin
      left_valid  = left_fill >= THRESH;
      right_valid = right_fill >= THRESH;
      opp_valid   = (ctrl.probe_side == SIDE_RIGHT) ? left_valid : right_valid;
      opp_key     = (ctrl.probe_side == SIDE_RIGHT) ? left_key_ff : right_key_ff;
      match_in    = match_ff;
      if (ctrl.load) begin
         match_in = opp_valid && (opp_key == probe_key);
      end else if (ctrl.take && grant) begin
         match_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign left_key  = left_key_ff;
   assign left_pay  = left_pay_ff;
   assign right_key = right_key_ff;
   assign right_pay = right_pay_ff;
   assign pending   = match_ff;
   assign sel_pay   = grant ? ((ctrl.probe_side == SIDE_RIGHT) ? left_pay_ff : right_pay_ff)
                            : '0;

endmodule

/* rtl/core/symmetric_stream_join.sv */
// symmetric stream join: a row of store cells probed by each incoming row
//
// req channel: one row per word (side, null flag, key, payload), valid/ready.
// rsp channel: one joined pair per word, valid/ready, last_match on the
// final pair caused by a row and the sticky store_overflow flag.
// when a row is taken, every cell compares its stored key of the
// opposite side against the row key and latches a match flag, while the
// row is shifted into the top of its own side's chain if that side has room.
// matches then leave one per cycle while the receiver takes them, oldest first,
// through the output register; a row with no match or a null key
// leaves req_ready high, so the next row follows at once.
// the first pair passes through the cell match flags and then the output register.
// req_ready is low while match flags are still waiting to leave; a stalled
// receiver holds the output register and so holds the drain and the input.
// reset empties both stores and clears the overflow flag;
// stale cell contents above the fill count are never compared.
module symmetric_stream_join #(
   parameter int ROWS_PER_SIDE = 64,
   parameter int KEY_BITS      = 64,
   parameter int PAYLOAD_BITS  = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ssj_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssj_pkg::rsp_type rsp_data
);
   import ssj_pkg::*;

   localparam int N  = ROWS_PER_SIDE;
   localparam int FW = $clog2(N + 1);
   localparam logic [FW-1:0] FULL = FW'(N);

   logic [FW-1:0]           left_fill_ff, left_fill_in, right_fill_ff, right_fill_in;
   logic                    overflow_ff, overflow_in;
   logic                    side_ff, side_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    accept, live, store_left, store_right, advance, emit, last;
   logic [KEY_BITS-1:0]     req_key;
   logic [PAYLOAD_BITS-1:0] req_pay, pick_pay;
   cell_ctrl_type           ctrl;
   logic [N-1:0]            pending, grant;
   logic [PAYLOAD_BITS-1:0] sel_pay [N];
   logic [KEY_BITS-1:0]     lk [N+1];
   logic [KEY_BITS-1:0]     rk [N+1];
   logic [PAYLOAD_BITS-1:0] lp [N+1];
   logic [PAYLOAD_BITS-1:0] rp [N+1];

   assign req_key = req_data.join_key[KEY_BITS-1:0];
   assign req_pay = req_data.row_payload[PAYLOAD_BITS-1:0];

   assign req_ready   = ~|pending;
   assign accept      = req_valid && req_ready;
   assign live        = accept && !req_data.key_is_null;
   assign store_left  = live && (req_data.opcode == SIDE_LEFT) && (left_fill_ff != FULL);
   assign store_right = live && (req_data.opcode == SIDE_RIGHT) && (right_fill_ff != FULL);
   assign advance     = !rsp_valid_ff || rsp_ready;
   assign emit        = advance && (|pending);
   assign grant       = pending & (~pending + N'(1));
   assign last        = (pending & ~grant) == '0;

   always_comb begin
      ctrl.load        = live;
      ctrl.probe_side  = live ? req_data.opcode : side_ff;
      ctrl.shift_left  = store_left;
      ctrl.shift_right = store_right;
      ctrl.take        = emit;
   end

   assign lk[N] = req_key;
   assign rk[N] = req_key;
   assign lp[N] = req_pay;
   assign rp[N] = req_pay;

   for (genvar j = 0; j < N; j++) begin : g_cell
      ssj_cell #(
         .ROWS_PER_SIDE (N),
         .KEY_BITS      (KEY_BITS),
         .PAYLOAD_BITS  (PAYLOAD_BITS),
         .INDEX         (j),
         .FW            (FW)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .probe_key    (req_key),
         .left_fill    (left_fill_ff),
         .right_fill   (right_fill_ff),
         .up_left_key  (lk[j+1]),
         .up_left_pay  (lp[j+1]),
         .up_right_key (rk[j+1]),
         .up_right_pay (rp[j+1]),
         .grant        (grant[j]),
         .left_key     (lk[j]),
         .left_pay     (lp[j]),
         .right_key    (rk[j]),
         .right_pay    (rp[j]),
         .pending      (pending[j]),
         .sel_pay      (sel_pay[j])
      );
   end

   always_comb begin
      pick_pay = '0;
      for (int j = 0; j < N; j++) begin
         pick_pay = pick_pay | sel_pay[j];
      end
   end

   always_comb begin
      left_fill_in  = left_fill_ff + FW'(store_left);
      right_fill_in = right_fill_ff + FW'(store_right);
      overflow_in   = overflow_ff || (live && !store_left && !store_right);
      side_in       = live ? req_data.opcode : side_ff;
      key_in        = live ? req_key : key_ff;
      pay_in        = live ? req_pay : pay_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.left_row       = (side_ff == SIDE_RIGHT) ? FIELD_BITS'(pick_pay)
                                                             : FIELD_BITS'(pay_ff);
         rsp_data_in.right_row      = (side_ff == SIDE_RIGHT) ? FIELD_BITS'(pay_ff)
                                                             : FIELD_BITS'(pick_pay);
         rsp_data_in.matched_key    = FIELD_BITS'(key_ff);
         rsp_data_in.last_match     = last;
         rsp_data_in.store_overflow = overflow_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_fill_ff  <= '0;
         right_fill_ff <= '0;
         overflow_ff   <= 1'b0;
         side_ff       <= SIDE_LEFT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         left_fill_ff  <= left_fill_in;
         right_fill_ff <= right_fill_in;
         overflow_ff   <= overflow_in;
         side_ff       <= side_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      pay_ff      <= pay_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_grant_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(grant))
      else $error("more than one cell granted");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (emit && last) |=> (pending == '0))
      else $error("match flags left after last word");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (left_fill_ff <= FULL) && (right_fill_ff <= FULL))
      else $error("store fill beyond capacity");

   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("overflow flag dropped");

   a_no_load_while_draining: assert property (@(posedge clock) disable iff (reset)
      (|pending) |-> !ctrl.load)
      else $error("probe loaded over pending matches");

endmodule
